// ----- rtl/core/csvt_pkg.sv -----
// Shared types and constants of the CSV field tokenizer.
// Used by every module under rtl/core; depends on nothing else.
package csvt_pkg;

    localparam int MAX_COLUMNS_DEF = 255;

    localparam logic [7:0]  CH_QUOTE = 8'h22;
    localparam logic [7:0]  CH_COMMA = 8'h2C;
    localparam logic [7:0]  CH_LF    = 8'h0A;
    localparam logic [7:0]  CH_CR    = 8'h0D;
    localparam logic [23:0] ROWS_MAX = 24'hFFFFFF;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOI  = 1'b1;

    localparam logic [1:0] KIND_CONTENT  = 2'd0;
    localparam logic [1:0] KIND_CELL_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END  = 2'd2;
    localparam logic [1:0] KIND_DISCARD  = 2'd3;

    localparam int         ADDR_W = 4;
    localparam logic [1:0] REG_ROW_LIMIT     = 2'd0;
    localparam logic [1:0] REG_HEADER_FIRST  = 2'd1;
    localparam logic [1:0] REG_ALLOW_PARTIAL = 2'd2;

    typedef struct packed {
        logic       operation;
        logic [7:0] input_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] empty_cells_before;
        logic       is_header;
        logic       limit_reached;
    } out_item_t;

    typedef struct packed {
        logic [23:0] row_limit;
        logic        header_first_row;
        logic        keep_partial_row;
    } cfg_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } result_t;

endpackage

// ----- rtl/core/csv_field_tokenizer_top.sv -----
// Throughput: 1 item per cycle while the output does not stall.
// The input register feeds the tokenizer logic, whose token lands in the result
// register; the input side stalls only while a token waits behind a stalled output.
// Reset (rst_n low, asynchronous) clears all parser state and the valid flags;
// configuration returns to row_limit 0, header_first_row 1, keep_partial_row 0.
module csv_field_tokenizer_top
    import csvt_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t     cfg;
    result_t  result;
    logic     s1_valid_reg;
    in_item_t s1_item_reg;
    logic     out_ready;
    logic     go;
    logic     s1_load;

    // Advance the held item unless its token cannot enter the result register
    assign go       = s1_valid_reg && (!result.valid || out_ready);
    assign s1_load  = !s1_valid_reg || go;
    assign in_stall = !s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
            s1_item_reg <= in_item;
    end

    csvt_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csvt_core #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .go     (go),
        .item   (s1_item_reg),
        .result (result)
    );

    csvt_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (go && result.valid),
        .load_item (result.item),
        .ready     (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// ----- rtl/core/csvt_apb_regs.sv -----
// APB configuration registers of the CSV field tokenizer.
// Depends on csvt_pkg for the register map and cfg_t.
module csvt_apb_regs
    import csvt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_limit        <= '0;
            cfg_reg.header_first_row <= 1'b1;
            cfg_reg.keep_partial_row <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ROW_LIMIT:     cfg_reg.row_limit <= pwdata[23:0];
                REG_HEADER_FIRST:  cfg_reg.header_first_row <= pwdata[0];
                REG_ALLOW_PARTIAL: cfg_reg.keep_partial_row <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ROW_LIMIT:     prdata = {8'd0, cfg_reg.row_limit};
            REG_HEADER_FIRST:  prdata = {31'd0, cfg_reg.header_first_row};
            REG_ALLOW_PARTIAL: prdata = {31'd0, cfg_reg.keep_partial_row};
            default:           prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/csvt_core.sv -----
// Tokenizer state and per-byte decision logic.
// Depends on csvt_pkg; state advances only when go is high.
module csvt_core
    import csvt_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     go,
    input  in_item_t item,
    output result_t  result
);

    localparam logic [7:0] EMPTY_CAP = (MAX_COLUMNS > 255) ? 8'd255 : 8'(MAX_COLUMNS);

    logic        in_quotes_reg, in_quotes_next;
    logic        quote_pending_reg, quote_pending_next;
    logic        skip_lf_reg, skip_lf_next;
    logic        cell_has_reg, cell_has_next;
    logic        row_has_reg, row_has_next;
    logic        row_open_reg, row_open_next;
    logic [7:0]  empty_pend_reg, empty_pend_next;
    logic        header_seen_reg, header_seen_next;
    logic [23:0] rows_reg, rows_next;
    logic        stopped_reg, stopped_next;

    logic       hdr_row;
    logic       do_content;
    logic       do_row_end;
    logic       iq_eff;
    logic [7:0] b;

    assign hdr_row = cfg.header_first_row && !header_seen_reg;
    assign b       = item.input_byte;

    always_comb
    begin
        in_quotes_next     = in_quotes_reg;
        quote_pending_next = quote_pending_reg;
        skip_lf_next       = skip_lf_reg;
        cell_has_next      = cell_has_reg;
        row_has_next       = row_has_reg;
        row_open_next      = row_open_reg;
        empty_pend_next    = empty_pend_reg;
        header_seen_next   = header_seen_reg;
        rows_next          = rows_reg;
        stopped_next       = stopped_reg;
        result             = '0;
        do_content         = 1'b0;
        do_row_end         = 1'b0;
        iq_eff             = in_quotes_reg;

        if (stopped_reg)
        begin
            result.valid = 1'b0;
        end
        else if (item.operation == OP_EOI)
        begin
            skip_lf_next = 1'b0;
            if ((row_open_reg || cell_has_reg) && cfg.keep_partial_row && row_has_reg)
            begin
                do_row_end = 1'b1;
            end
            else
            begin
                // Drop the open row; flag its discard unless partial rows are kept
                in_quotes_next     = 1'b0;
                quote_pending_next = 1'b0;
                cell_has_next      = 1'b0;
                row_has_next       = 1'b0;
                row_open_next      = 1'b0;
                empty_pend_next    = '0;
                if ((row_open_reg || cell_has_reg) && !cfg.keep_partial_row)
                begin
                    result.valid          = 1'b1;
                    result.item.kind      = KIND_DISCARD;
                    result.item.is_header = hdr_row && row_has_reg;
                end
            end
        end
        else
        begin
            skip_lf_next = 1'b0;
            if (!(skip_lf_reg && b == CH_LF))
            begin
                if (quote_pending_reg)
                begin
                    quote_pending_next = 1'b0;
                    if (b != CH_QUOTE)
                    begin
                        iq_eff         = 1'b0;
                        in_quotes_next = 1'b0;
                    end
                end

                if (quote_pending_reg && b == CH_QUOTE)
                begin
                    do_content = 1'b1;
                end
                else if (b == CH_QUOTE)
                begin
                    if (iq_eff)
                        quote_pending_next = 1'b1;
                    else if (!cell_has_reg)
                        in_quotes_next = 1'b1;
                    else
                        do_content = 1'b1;
                end
                else if (iq_eff)
                begin
                    do_content = 1'b1;
                end
                else if (b == CH_COMMA)
                begin
                    row_open_next = 1'b1;
                    cell_has_next = 1'b0;
                    if (row_has_reg)
                    begin
                        result.valid          = 1'b1;
                        result.item.kind      = KIND_CELL_END;
                        result.item.is_header = hdr_row;
                    end
                    else if (empty_pend_reg < EMPTY_CAP)
                    begin
                        empty_pend_next = empty_pend_reg + 8'd1;
                    end
                end
                else if (b == CH_LF || b == CH_CR)
                begin
                    skip_lf_next = (b == CH_CR);
                    if (row_has_reg)
                    begin
                        do_row_end = 1'b1;
                    end
                    else
                    begin
                        // Row without content ends silently
                        in_quotes_next     = 1'b0;
                        quote_pending_next = 1'b0;
                        cell_has_next      = 1'b0;
                        row_open_next      = 1'b0;
                        empty_pend_next    = '0;
                    end
                end
                else
                begin
                    do_content = 1'b1;
                end
            end
        end

        if (do_content)
        begin
            result.valid          = 1'b1;
            result.item.kind      = KIND_CONTENT;
            result.item.data_byte = b;
            result.item.is_header = hdr_row;
            if (!row_has_reg)
                result.item.empty_cells_before = empty_pend_reg;
            row_has_next  = 1'b1;
            cell_has_next = 1'b1;
        end

        if (do_row_end)
        begin
            result.valid          = 1'b1;
            result.item.kind      = KIND_ROW_END;
            result.item.is_header = hdr_row;
            if (hdr_row)
            begin
                header_seen_next = 1'b1;
            end
            else
            begin
                rows_next = (rows_reg == ROWS_MAX) ? rows_reg : rows_reg + 24'd1;
                if (cfg.row_limit != '0 && rows_next >= cfg.row_limit)
                begin
                    result.item.limit_reached = 1'b1;
                    stopped_next              = 1'b1;
                end
            end
            in_quotes_next     = 1'b0;
            quote_pending_next = 1'b0;
            cell_has_next      = 1'b0;
            row_has_next       = 1'b0;
            row_open_next      = 1'b0;
            empty_pend_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg     <= 1'b0;
            quote_pending_reg <= 1'b0;
            skip_lf_reg       <= 1'b0;
            cell_has_reg      <= 1'b0;
            row_has_reg       <= 1'b0;
            row_open_reg      <= 1'b0;
            empty_pend_reg    <= '0;
            header_seen_reg   <= 1'b0;
            rows_reg          <= '0;
            stopped_reg       <= 1'b0;
        end
        else if (go)
        begin
            in_quotes_reg     <= in_quotes_next;
            quote_pending_reg <= quote_pending_next;
            skip_lf_reg       <= skip_lf_next;
            cell_has_reg      <= cell_has_next;
            row_has_reg       <= row_has_next;
            row_open_reg      <= row_open_next;
            empty_pend_reg    <= empty_pend_next;
            header_seen_reg   <= header_seen_next;
            rows_reg          <= rows_next;
            stopped_reg       <= stopped_next;
        end
    end

endmodule

// ----- rtl/core/csvt_out_stage.sv -----
// Result register of the CSV field tokenizer, driving the output channel.
// Depends on csvt_pkg for out_item_t.
module csvt_out_stage
    import csvt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t load_item,
    output logic      ready,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic      valid_reg;
    out_item_t item_reg;

    // Free when empty or when the held item leaves at this edge
    assign ready     = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load && ready)
            item_reg <= load_item;
    end

endmodule
